[hdl/iva_pkg.sv]
// ----------------------------------------------------------------------------
// iva_pkg
// Shared types and constants of the interrupt vector allocator: stream
// layout, register map, operation and status codes, sequencer states.
// ----------------------------------------------------------------------------
`default_nettype none

package iva_pkg;

  // stream words
  localparam int TDATA_W  = 16;
  localparam int IN_TUSER_W  = 2;
  localparam int OUT_TUSER_W = 2;
  localparam int CPU_IDX_W   = 3;
  localparam int VEC_W       = 8;

  // map words are 64 bits wide
  localparam int MAP_BITS  = 64;
  localparam int BITSEL_W  = 6;

  // configuration port
  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;
  localparam int CPU_LIMIT_W = 4;
  localparam logic [APB_ADDR_W-1:0]  ADDR_CPU_LIMIT  = 3'h0;
  localparam logic [CPU_LIMIT_W-1:0] CPU_LIMIT_RESET = 4'd1;

  // operation kinds
  localparam logic KIND_RESERVE = 1'b0;
  localparam logic KIND_RELEASE = 1'b1;

  // result status
  typedef logic [1:0] status_t;
  localparam status_t STATUS_OK        = 2'd0;
  localparam status_t STATUS_NONE_FREE = 2'd1;
  localparam status_t STATUS_BAD       = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_CHECK,
    ST_FINISH
  } iva_state_t;

endpackage

`default_nettype wire

[hdl/iva_ram.sv]
// ----------------------------------------------------------------------------
// iva_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module iva_ram #(
  parameter int WIDTH  = 64,
  parameter int DEPTH  = 32,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [WIDTH-1:0]  wdata,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

[hdl/iva_scan.sv]
// ----------------------------------------------------------------------------
// iva_scan
// Find-first-free unit: lowest clear bit of one map word that lies in the
// allocatable vector range.
// ----------------------------------------------------------------------------
`default_nettype none

module iva_scan
  import iva_pkg::*;
#(
  parameter int VECTOR_COUNT = 256,
  parameter int FIRST_VECTOR = 32,
  parameter int WORD_W       = 2
) (
  input  wire logic [WORD_W-1:0]   word_idx,
  input  wire logic [MAP_BITS-1:0] word,
  output logic                     found,
  output logic [BITSEL_W-1:0]      bit_pos
);

  logic [MAP_BITS-1:0] range_mask;
  logic [MAP_BITS-1:0] cand;

  always_comb begin
    int vnum;
    vnum = 0;
    for (int b = 0; b < MAP_BITS; b++) begin
      vnum = int'(word_idx) * MAP_BITS + b;
      range_mask[b] = (vnum >= FIRST_VECTOR) && (vnum < VECTOR_COUNT);
    end
  end

  assign cand = ~word & range_mask;

  // lowest candidate wins
  always_comb begin
    found   = 1'b0;
    bit_pos = '0;
    for (int b = MAP_BITS - 1; b >= 0; b--) begin
      if (cand[b]) begin
        found   = 1'b1;
        bit_pos = BITSEL_W'(b);
      end
    end
  end

endmodule

`default_nettype wire

[hdl/interrupt_vector_allocator.sv]
// ----------------------------------------------------------------------------
// interrupt_vector_allocator
// Per-CPU bitmap allocator of interrupt vectors: reserve lowest free vector
// on one CPU or the first CPU that has one, release a reserved vector.
// ----------------------------------------------------------------------------
//  port group   dir   word contents
//  s_*          in    tuser: kind, any_cpu   tdata: cpu_index, vector
//  m_*          out   tuser: status          tdata: granted_cpu, granted_vector
//  apb          in    register 0 cpu_limit at byte address 0
//
//  Each map word visited passes through ST_READ (RAM read) and ST_CHECK (scan
//  and write-back); an item is taken in ST_IDLE and handed off in ST_FINISH.
//  A release visits one word, a named reserve up to MAP_WORDS words, an any-CPU
//  reserve up to MAP_WORDS words per enabled CPU. Out-of-range items skip the map.
//  Reset is synchronous; map words read as zero until first written, so no
//  clearing pass is needed. A new word is taken while a result waits on m_*.
// ----------------------------------------------------------------------------
`default_nettype none

module interrupt_vector_allocator
  import iva_pkg::*;
#(
  parameter int MAX_CPUS     = 8,
  parameter int VECTOR_COUNT = 256,
  parameter int FIRST_VECTOR = 32
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  // input stream
  input  wire logic                   s_tvalid,
  output logic                        s_tready,
  input  wire logic [TDATA_W-1:0]     s_tdata,   // [2:0] cpu_index, [10:3] vector
  input  wire logic [IN_TUSER_W-1:0]  s_tuser,   // [0] kind, [1] any_cpu
  // result stream
  output logic                        m_tvalid,
  input  wire logic                   m_tready,
  output logic      [TDATA_W-1:0]     m_tdata,   // [2:0] granted_cpu, [10:3] granted_vector
  output logic      [OUT_TUSER_W-1:0] m_tuser,   // [1:0] status
  // configuration
  input  wire logic                   psel,
  input  wire logic                   penable,
  input  wire logic                   pwrite,
  input  wire logic [APB_ADDR_W-1:0]  paddr,
  input  wire logic [APB_DATA_W-1:0]  pwdata,
  output logic      [APB_DATA_W-1:0]  prdata,
  output logic                        pready
);

  localparam int MAP_WORDS = (VECTOR_COUNT + MAP_BITS - 1) / MAP_BITS;
  localparam int DEPTH     = MAX_CPUS * MAP_WORDS;
  localparam int ADDR_W    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int WORD_W    = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int CPU_W     = (MAX_CPUS > 1) ? $clog2(MAX_CPUS) : 1;
  localparam logic [WORD_W-1:0] LAST_WORD = WORD_W'(MAP_WORDS - 1);

  // ---------------- configuration ----------------
  logic [CPU_LIMIT_W-1:0] cpu_limit;
  logic [CPU_LIMIT_W-1:0] ncpu;

  assign pready = 1'b1;
  assign prdata = (paddr == ADDR_CPU_LIMIT) ?
                  APB_DATA_W'(cpu_limit) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      cpu_limit <= CPU_LIMIT_RESET;
    end else if (psel && penable && pwrite && pready && paddr == ADDR_CPU_LIMIT) begin
      cpu_limit <= pwdata[CPU_LIMIT_W-1:0];
    end
  end

  assign ncpu = (int'(cpu_limit) > MAX_CPUS) ? CPU_LIMIT_W'(MAX_CPUS) : cpu_limit;

  // ---------------- sequencer registers ----------------
  iva_state_t state, state_next;

  logic                 op_kind, op_kind_next;
  logic                 op_any, op_any_next;
  logic [CPU_IDX_W-1:0] op_cpu, op_cpu_next;
  logic [VEC_W-1:0]     op_vec, op_vec_next;
  logic [CPU_W-1:0]     cur_cpu, cur_cpu_next;
  logic [WORD_W-1:0]    cur_word, cur_word_next;

  logic [CPU_IDX_W-1:0] res_cpu, res_cpu_next;
  logic [VEC_W-1:0]     res_vec, res_vec_next;
  status_t              res_status, res_status_next;

  logic                 out_load;

  // ---------------- map storage ----------------
  logic [ADDR_W-1:0]   map_addr;
  logic [MAP_BITS-1:0] map_rdata;
  logic [MAP_BITS-1:0] map_word;
  logic [MAP_BITS-1:0] map_wdata;
  logic                map_we;
  logic [DEPTH-1:0]    word_valid;
  logic                rd_valid;

  assign map_addr = ADDR_W'(int'(cur_cpu) * MAP_WORDS + int'(cur_word));

  iva_ram #(
    .WIDTH  (MAP_BITS),
    .DEPTH  (DEPTH),
    .ADDR_W (ADDR_W)
  ) u_map (
    .clk   (clk),
    .we    (map_we),
    .waddr (map_addr),
    .wdata (map_wdata),
    .raddr (map_addr),
    .rdata (map_rdata)
  );

  // words never written read as all free
  always_ff @(posedge clk) begin
    if (rst) begin
      word_valid <= '0;
      rd_valid   <= 1'b0;
    end else begin
      rd_valid <= word_valid[map_addr];
      if (map_we) begin
        word_valid[map_addr] <= 1'b1;
      end
    end
  end

  assign map_word = rd_valid ? map_rdata : '0;

  // ---------------- shared scan unit ----------------
  logic                scan_found;
  logic [BITSEL_W-1:0] scan_pos;
  logic [BITSEL_W-1:0] sel_bit;
  logic [MAP_BITS-1:0] sel_onehot;

  iva_scan #(
    .VECTOR_COUNT (VECTOR_COUNT),
    .FIRST_VECTOR (FIRST_VECTOR),
    .WORD_W       (WORD_W)
  ) u_scan (
    .word_idx (cur_word),
    .word     (map_word),
    .found    (scan_found),
    .bit_pos  (scan_pos)
  );

  assign sel_bit    = (op_kind == KIND_RELEASE) ? op_vec[BITSEL_W-1:0] : scan_pos;
  assign sel_onehot = MAP_BITS'(1) << sel_bit;
  assign map_wdata  = (op_kind == KIND_RELEASE) ? (map_word & ~sel_onehot)
                                                : (map_word | sel_onehot);

  // ---------------- next state ----------------
  logic [CPU_IDX_W-1:0] in_cpu;
  logic [VEC_W-1:0]     in_vec;
  logic                 in_kind;
  logic                 in_any;
  logic                 in_cpu_bad;

  assign in_cpu     = s_tdata[CPU_IDX_W-1:0];
  assign in_vec     = s_tdata[CPU_IDX_W +: VEC_W];
  assign in_kind    = s_tuser[0];
  assign in_any     = s_tuser[1];
  assign in_cpu_bad = {1'b0, in_cpu} >= ncpu;
  assign s_tready   = (state == ST_IDLE);

  always_comb begin
    state_next      = state;
    op_kind_next    = op_kind;
    op_any_next     = op_any;
    op_cpu_next     = op_cpu;
    op_vec_next     = op_vec;
    cur_cpu_next    = cur_cpu;
    cur_word_next   = cur_word;
    res_cpu_next    = res_cpu;
    res_vec_next    = res_vec;
    res_status_next = res_status;
    map_we          = 1'b0;
    out_load        = 1'b0;

    case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          op_kind_next  = in_kind;
          op_any_next   = in_any;
          op_cpu_next   = in_cpu;
          op_vec_next   = in_vec;
          cur_cpu_next  = CPU_W'(in_cpu);
          cur_word_next = '0;
          res_cpu_next  = in_cpu;
          res_vec_next  = '0;
          state_next    = ST_READ;
          if (in_kind == KIND_RELEASE) begin
            res_vec_next  = in_vec;
            cur_word_next = WORD_W'(in_vec >> BITSEL_W);
            if (in_cpu_bad || int'(in_vec) >= VECTOR_COUNT) begin
              res_status_next = STATUS_BAD;
              state_next      = ST_FINISH;
            end
          end else if (in_any) begin
            cur_cpu_next = '0;
            res_cpu_next = '0;
            if (ncpu == '0) begin
              res_status_next = STATUS_NONE_FREE;
              state_next      = ST_FINISH;
            end
          end else if (in_cpu_bad) begin
            res_status_next = STATUS_BAD;
            state_next      = ST_FINISH;
          end
        end
      end

      ST_READ: begin
        state_next = ST_CHECK;
      end

      ST_CHECK: begin
        if (op_kind == KIND_RELEASE) begin
          state_next = ST_FINISH;
          if (map_word[sel_bit]) begin
            map_we          = 1'b1;
            res_status_next = STATUS_OK;
          end else begin
            res_status_next = STATUS_BAD;
          end
        end else if (scan_found) begin
          map_we          = 1'b1;
          res_cpu_next    = CPU_IDX_W'(cur_cpu);
          res_vec_next    = VEC_W'({cur_word, scan_pos});
          res_status_next = STATUS_OK;
          state_next      = ST_FINISH;
        end else if (cur_word != LAST_WORD) begin
          cur_word_next = cur_word + 1'b1;
          state_next    = ST_READ;
        end else if (op_any && (int'(cur_cpu) + 1 < int'(ncpu))) begin
          cur_cpu_next  = cur_cpu + 1'b1;
          cur_word_next = '0;
          state_next    = ST_READ;
        end else begin
          // nothing free: any-cpu search reports cpu 0
          res_cpu_next    = op_any ? '0 : op_cpu;
          res_vec_next    = '0;
          res_status_next = STATUS_NONE_FREE;
          state_next      = ST_FINISH;
        end
      end

      ST_FINISH: begin
        if (!m_tvalid || m_tready) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    op_kind    <= op_kind_next;
    op_any     <= op_any_next;
    op_cpu     <= op_cpu_next;
    op_vec     <= op_vec_next;
    cur_cpu    <= cur_cpu_next;
    cur_word   <= cur_word_next;
    res_cpu    <= res_cpu_next;
    res_vec    <= res_vec_next;
    res_status <= res_status_next;
  end

  // ---------------- output register ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= TDATA_W'({res_vec, res_cpu});
      m_tuser <= res_status;
    end
  end

endmodule

`default_nettype wire
